// ===== rtl/bfrb_pkg.sv =====
package bfrb_pkg;

   // Field widths of the item and result channels
   localparam int FUNC_W   = 3;
   localparam int DATA_W   = 8;
   localparam int LEN_W    = 7;
   localparam int OFS_W    = 10;
   localparam int STATUS_W = 2;
   localparam int PEND_W   = 10;

   // Defaults for the top-level parameters
   localparam int SLOTS_DEF    = 1024;
   localparam int MAX_READ_DEF = 64;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Function codes on the request channel
   localparam logic [FUNC_W-1:0] FUNC_WRITE    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ_OFS = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_COMMIT   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_ROLLBACK = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_STATUS   = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd6;

   // Status codes on the response channel
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OFS_OVER = 2'd3;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_READ,
      OP_READ_OFS,
      OP_COMMIT,
      OP_ROLLBACK,
      OP_STATUS,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [DATA_W-1:0]   wr_data;
      logic [LEN_W-1:0]    rd_length;
      logic [OFS_W-1:0]    rd_offset;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ
   } back_state_type;

endpackage

// ===== rtl/bfrb_if.sv =====
interface bfrb_req_if import bfrb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [DATA_W-1:0]   wr_data;
   logic [LEN_W-1:0]    rd_length;
   logic [OFS_W-1:0]    rd_offset;

   modport source (output valid, output func, output wr_data, output rd_length,
                   output rd_offset, input ready);
   modport sink (input valid, input func, input wr_data, input rd_length,
                 input rd_offset, output ready);
endinterface

interface bfrb_rsp_if import bfrb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   rd_data;
   logic                last;
   logic [PEND_W-1:0]   pending;
   logic                is_full;
   logic                is_empty;

   modport source (output valid, output status, output rd_data, output last,
                   output pending, output is_full, output is_empty, input ready);
   modport sink (input valid, input status, input rd_data, input last,
                 input pending, input is_full, input is_empty, output ready);
endinterface

// ===== rtl/byte_fifo_with_read_rollback_core.sv =====
// Path: a single-result item goes through the command queue and the result register;
//   a read also passes the state check and the store's registered read port, then gives
//   one byte per cycle while the receiver is ready. Throughput: 1 item per cycle for
//   single-result items while ready; a read holds the back end until its last byte.
// Reset: synchronous, active high; clears all pointers, the command queue and the
//   result valid flag. Store contents stay undefined and are never sent before written.
module byte_fifo_with_read_rollback_core import bfrb_pkg::*; #(
   parameter int SLOTS    = SLOTS_DEF,
   parameter int MAX_READ = MAX_READ_DEF
) (
   input  logic         clock,
   input  logic         reset,
   bfrb_req_if.sink     req_ch,
   bfrb_rsp_if.source   rsp_ch
);

   // Front: decode func, saturate the read length, push into the queue
   logic      push_valid;
   logic      push_ready;
   cmd_type   push_cmd;

   // Back side of the queue
   logic      cmd_valid;
   logic      cmd_pop;
   cmd_type   cmd;

   bfrb_front #(
      .MAX_READ (MAX_READ)
   ) u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   // Two-entry queue: lets the front keep taking items while a read streams out
   bfrb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_cmd    (push_cmd),
      .in_ready  (push_ready),
      .out_valid (cmd_valid),
      .out_cmd   (cmd),
      .out_pop   (cmd_pop)
   );

   // Back: owns the pointers and the byte store, builds every result item
   bfrb_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_ch    (rsp_ch)
   );

   // A full flag always comes with a pending count of one less than the slot count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.is_full) |-> (rsp_ch.pending == PEND_W'(SLOTS - 1)))
      else $error("is_full without matching pending count");

   // A refused write leaves the FIFO full
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == STATUS_FULL)) |-> rsp_ch.is_full)
      else $error("write refused while not full");

   // Any error ends its item and carries no byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != STATUS_OK)) |->
         (rsp_ch.last && (rsp_ch.rd_data == '0)))
      else $error("error result not final or carries data");

   // Inside a read burst the next byte follows in the very next cycle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last) |=> rsp_ch.valid)
      else $error("gap inside a read burst");

endmodule

// ===== rtl/bfrb_front.sv =====
module bfrb_front import bfrb_pkg::*; #(
   parameter int MAX_READ = MAX_READ_DEF
) (
   bfrb_req_if.sink     req_ch,
   output logic         push_valid,
   output cmd_type      push_cmd,
   input  logic         push_ready
);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_READ);

   op_type op;

   // Decode the function code; the unused code behaves as status
   always_comb begin
      unique case (req_ch.func)
         FUNC_WRITE:    op = OP_WRITE;
         FUNC_READ:     op = OP_READ;
         FUNC_READ_OFS: op = OP_READ_OFS;
         FUNC_COMMIT:   op = OP_COMMIT;
         FUNC_ROLLBACK: op = OP_ROLLBACK;
         FUNC_CLEAR:    op = OP_CLEAR;
         default:       op = OP_STATUS;
      endcase
   end

   always_comb begin
      push_cmd.op        = op;
      push_cmd.wr_data   = req_ch.wr_data;
      push_cmd.rd_offset = req_ch.rd_offset;
      // Saturate the read length
      push_cmd.rd_length = (req_ch.rd_length > MAX_LEN) ? MAX_LEN : req_ch.rd_length;
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

endmodule

// ===== rtl/bfrb_queue.sv =====
module bfrb_queue import bfrb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  cmd_type   in_cmd,
   output logic      in_ready,
   output logic      out_valid,
   output cmd_type   out_cmd,
   input  logic      out_pop
);

   localparam logic [QIDX_W-1:0] LAST_IDX = QIDX_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0]   head_ff, head_in;
   logic [QIDX_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[head_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_pop;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= in_cmd;
      end
   end

endmodule

// ===== rtl/bfrb_back.sv =====
module bfrb_back import bfrb_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_pop,
   bfrb_rsp_if.source   rsp_ch
);

   localparam int PTR_W = $clog2(SLOTS);
   localparam int CMP_W = (PTR_W > OFS_W) ? PTR_W : OFS_W;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);
   localparam logic [PTR_W:0]   SLOTS_EXT = (PTR_W + 1)'(SLOTS);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] from,
                                                 input logic [PTR_W-1:0] to);
      logic [PTR_W:0] diff;
      diff = {1'b0, to} - {1'b0, from};
      if (diff[PTR_W]) begin
         diff = diff + SLOTS_EXT;
      end
      return diff[PTR_W-1:0];
   endfunction

   back_state_type      state_ff, state_in;
   logic [PTR_W-1:0]    wr_ff, wr_in;
   logic [PTR_W-1:0]    rd_ff, rd_in;
   logic [PTR_W-1:0]    mark_ff, mark_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [DATA_W-1:0]   store_mem [SLOTS];
   logic [DATA_W-1:0]   rdata_ff;
   logic                mem_we;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [DATA_W-1:0]   data_ff;
   logic                last_ff;
   logic [PEND_W-1:0]   pending_ff;
   logic                full_ff;
   logic                empty_ff;

   logic                emit;
   logic [STATUS_W-1:0] emit_status;
   logic [DATA_W-1:0]   emit_data;
   logic                emit_last;

   logic                slot_free;
   logic                is_full_now;
   logic [PTR_W-1:0]    pend_now;
   logic                ofs_bad;
   logic [PTR_W:0]      ofs_sum;
   logic [PTR_W-1:0]    ofs_start;
   logic                len_short;
   logic                fetch;

   assign slot_free   = !rsp_valid_ff || rsp_ch.ready;
   assign fetch       = (state_ff == ST_IDLE) && cmd_valid && slot_free;
   assign is_full_now = (ptr_inc(wr_ff) == mark_ff);
   assign pend_now    = ptr_dist(mark_ff, wr_ff);
   assign ofs_bad     = CMP_W'(cmd.rd_offset) > CMP_W'(pend_now);
   assign ofs_sum     = {1'b0, mark_ff} + (PTR_W + 1)'(cmd.rd_offset);
   assign ofs_start   = (ofs_sum >= SLOTS_EXT) ? PTR_W'(ofs_sum - SLOTS_EXT)
                                                : ofs_sum[PTR_W-1:0];
   assign len_short   = CMP_W'(len_ff) > CMP_W'(ptr_dist(rd_ff, wr_ff));

   // Datapath and result selection
   always_comb begin
      wr_in       = wr_ff;
      rd_in       = rd_ff;
      mark_in     = mark_ff;
      len_in      = len_ff;
      mem_we      = 1'b0;
      cmd_pop     = 1'b0;
      emit        = 1'b0;
      emit_status = STATUS_OK;
      emit_data   = '0;
      emit_last   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (fetch) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_WRITE: begin
                     emit = 1'b1;
                     if (is_full_now) begin
                        emit_status = STATUS_FULL;
                     end else begin
                        mem_we = 1'b1;
                        wr_in  = ptr_inc(wr_ff);
                     end
                  end
                  OP_READ: begin
                     len_in = cmd.rd_length;
                  end
                  OP_READ_OFS: begin
                     if (ofs_bad) begin
                        emit        = 1'b1;
                        emit_status = STATUS_OFS_OVER;
                     end else begin
                        rd_in  = ofs_start;
                        len_in = cmd.rd_length;
                     end
                  end
                  OP_COMMIT: begin
                     mark_in = rd_ff;
                     emit    = 1'b1;
                  end
                  OP_ROLLBACK: begin
                     rd_in = mark_ff;
                     emit  = 1'b1;
                  end
                  OP_CLEAR: begin
                     wr_in   = '0;
                     rd_in   = '0;
                     mark_in = '0;
                     emit    = 1'b1;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (len_ff == '0) begin
               emit = slot_free;
            end else if (len_short) begin
               if (slot_free) begin
                  rd_in       = mark_ff;
                  emit        = 1'b1;
                  emit_status = STATUS_SHORT;
               end
            end
         end
         ST_READ: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_data = rdata_ff;
               emit_last = (len_ff == LEN_W'(1));
               rd_in     = ptr_inc(rd_ff);
               len_in    = len_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fetch && ((cmd.op == OP_READ) || ((cmd.op == OP_READ_OFS) && !ofs_bad))) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((len_ff != '0) && !len_short) begin
               state_in = ST_READ;
            end else if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (slot_free && (len_ff == LEN_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ff        <= '0;
         rd_ff        <= '0;
         mark_ff      <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         mark_ff      <= mark_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register; flags show the pointers after this result's effect
   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff  <= emit_status;
         data_ff    <= emit_data;
         last_ff    <= emit_last;
         pending_ff <= PEND_W'(ptr_dist(mark_in, wr_in));
         full_ff    <= (ptr_inc(wr_in) == mark_in);
         empty_ff   <= (rd_in == wr_in);
      end
   end

   // Byte store; the read port follows the next read pointer every cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_ff] <= cmd.wr_data;
      end
      rdata_ff <= store_mem[rd_in];
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = status_ff;
   assign rsp_ch.rd_data  = data_ff;
   assign rsp_ch.last     = last_ff;
   assign rsp_ch.pending  = pending_ff;
   assign rsp_ch.is_full  = full_ff;
   assign rsp_ch.is_empty = empty_ff;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import bfrb_pkg::*;

   localparam int SLOTS       = SLOTS_DEF;
   localparam int MAX_READ    = MAX_READ_DEF;
   localparam int PTR_W       = $clog2(SLOTS);
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 10;

   // Code 7 is not decoded by the block; it must behave as a status query.
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   rd_data;
      logic                last;
      logic [PEND_W-1:0]   pending;
      logic                is_full;
      logic                is_empty;
   } fifo_rsp_type;

   logic clock;
   logic reset;

   bfrb_req_if req ();
   bfrb_rsp_if rsp ();

   byte_fifo_with_read_rollback_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp)
   );

   // Shadow copy of the FIFO: store, write pointer, speculative read pointer
   // and committed mark. Updated at the edge where each item is accepted.
   logic [DATA_W-1:0] mirror_mem [SLOTS];
   logic [PTR_W-1:0]  mirror_wr;
   logic [PTR_W-1:0]  mirror_rd;
   logic [PTR_W-1:0]  mirror_mark;

   // Responses the block still owes, oldest first.
   fifo_rsp_type due_rsp_q [$];

   int n_fail;
   int quiet_cycles;
   int tx_idle_pct;
   int rx_idle_pct;

   always #10 clock = ~clock;

   // Distance from one pointer forward to another; wraps with the pointer width.
   function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] tail,
                                                 input logic [PTR_W-1:0] head);
      return head - tail;
   endfunction

   // Queue one response that reflects the shadow state as it stands now.
   task automatic owe_rsp(input logic [STATUS_W-1:0] st, input logic [DATA_W-1:0] b,
                          input logic lst);
      fifo_rsp_type r;
      r.status   = st;
      r.rd_data  = b;
      r.last     = lst;
      r.pending  = PEND_W'(ptr_dist(mirror_mark, mirror_wr));
      r.is_full  = (PTR_W'(mirror_wr + 1'b1) == mirror_mark);
      r.is_empty = (mirror_rd == mirror_wr);
      due_rsp_q.push_back(r);
   endtask

   // Read from the current read pointer: saturate the length, give one empty response
   // for zero, refuse a short read by snapping back to the mark, else one per byte.
   task automatic mirror_read(input logic [LEN_W-1:0] len);
      int n;
      n = (int'(len) > MAX_READ) ? MAX_READ : int'(len);
      if (n == 0) begin
         owe_rsp(STATUS_OK, '0, 1'b1);
      end else if (n > int'(ptr_dist(mirror_rd, mirror_wr))) begin
         mirror_rd = mirror_mark;
         owe_rsp(STATUS_SHORT, '0, 1'b1);
      end else begin
         for (int i = 0; i < n; i++) begin
            logic [DATA_W-1:0] b;
            b = mirror_mem[mirror_rd];
            mirror_rd = mirror_rd + 1'b1;
            owe_rsp(STATUS_OK, b, (i == n - 1));
         end
      end
   endtask

   // Apply one accepted item to the shadow FIFO and queue what it must return.
   task automatic mirror_apply(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] d,
                               input logic [LEN_W-1:0] len, input logic [OFS_W-1:0] ofs);
      case (f)
         FUNC_WRITE: begin
            if (PTR_W'(mirror_wr + 1'b1) == mirror_mark) begin
               owe_rsp(STATUS_FULL, '0, 1'b1);
            end else begin
               mirror_mem[mirror_wr] = d;
               mirror_wr = mirror_wr + 1'b1;
               owe_rsp(STATUS_OK, '0, 1'b1);
            end
         end
         FUNC_READ: begin
            mirror_read(len);
         end
         FUNC_READ_OFS: begin
            if (int'(ofs) > int'(ptr_dist(mirror_mark, mirror_wr))) begin
               owe_rsp(STATUS_OFS_OVER, '0, 1'b1);
            end else begin
               mirror_rd = mirror_mark + PTR_W'(ofs);
               mirror_read(len);
            end
         end
         FUNC_COMMIT: begin
            mirror_mark = mirror_rd;
            owe_rsp(STATUS_OK, '0, 1'b1);
         end
         FUNC_ROLLBACK: begin
            mirror_rd = mirror_mark;
            owe_rsp(STATUS_OK, '0, 1'b1);
         end
         FUNC_CLEAR: begin
            // Stale bytes stay in the shadow store; they lie outside the pointers.
            mirror_wr   = '0;
            mirror_rd   = '0;
            mirror_mark = '0;
            owe_rsp(STATUS_OK, '0, 1'b1);
         end
         default: begin
            owe_rsp(STATUS_OK, '0, 1'b1);
         end
      endcase
   endtask

   // Present one item, idling first at the current sender rate, and hold it
   // until accepted. Valid stays high afterwards so back-to-back items need no
   // second assignment in the same step; drop_req lowers it before any wait.
   task automatic send_item(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] d,
                            input logic [LEN_W-1:0] len, input logic [OFS_W-1:0] ofs);
      while ($urandom_range(99) < tx_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.func      <= f;
      req.wr_data   <= d;
      req.rd_length <= len;
      req.rd_offset <= ofs;
      do @(posedge clock); while (!req.ready);
      mirror_apply(f, d, len, ofs);
   endtask

   task automatic drop_req();
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off the sender until every owed response has come back.
   task automatic wait_drained();
      drop_req();
      while (due_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Extremes of the fields, every function code and every special case but a refused
   // write, on a small population of bytes.
   task automatic test_directed();
      tx_idle_pct = 34;
      rx_idle_pct = 66;
      send_item(FUNC_STATUS, 8'h00, 7'd0, 10'd0);
      send_item(FUNC_SPARE, 8'hFF, 7'h7F, 10'h3FF);
      send_item(FUNC_READ, 8'h00, 7'd0, 10'd0);       // zero length on empty
      send_item(FUNC_READ, 8'h00, 7'd1, 10'd0);       // short read on empty
      send_item(FUNC_READ_OFS, 8'h00, 7'd1, 10'd1);   // offset beyond nothing held
      send_item(FUNC_WRITE, 8'h00, 7'd0, 10'd0);
      send_item(FUNC_WRITE, 8'hFF, 7'd0, 10'd0);
      send_item(FUNC_WRITE, 8'hA5, 7'd0, 10'd0);
      send_item(FUNC_WRITE, 8'h5A, 7'd0, 10'd0);
      send_item(FUNC_READ, 8'h00, 7'd2, 10'd0);
      send_item(FUNC_COMMIT, 8'h00, 7'd0, 10'd0);
      send_item(FUNC_READ, 8'h00, 7'd3, 10'd0);       // short: read pointer snaps back
      send_item(FUNC_READ, 8'h00, 7'd2, 10'd0);
      send_item(FUNC_ROLLBACK, 8'h00, 7'd0, 10'd0);
      send_item(FUNC_READ_OFS, 8'h00, 7'd1, 10'd1);
      send_item(FUNC_READ_OFS, 8'h00, 7'd0, 10'd2);   // zero length still sets rd
      send_item(FUNC_READ_OFS, 8'h00, 7'd1, 10'd3);   // offset one past pending
      send_item(FUNC_READ_OFS, 8'h00, 7'h7F, 10'h3FF);
      send_item(FUNC_READ, 8'h00, 7'h7F, 10'd0);      // saturated, still short
      send_item(FUNC_COMMIT, 8'h00, 7'd0, 10'd0);
      send_item(FUNC_CLEAR, 8'h00, 7'd0, 10'd0);
      send_item(FUNC_STATUS, 8'h00, 7'd0, 10'd0);
      wait_drained();
   endtask

   // Hold a little more than one maximal burst, pull a saturated read through
   // and step around the remainder with offset reads.
   task automatic test_full_burst();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_item(FUNC_CLEAR, DATA_W'($urandom), LEN_W'($urandom), OFS_W'($urandom));
      repeat (MAX_READ + 2) begin
         send_item(FUNC_WRITE, DATA_W'($urandom), LEN_W'($urandom), OFS_W'($urandom));
      end
      send_item(FUNC_READ, 8'h00, 7'h7F, 10'd0);      // clipped to a full burst
      send_item(FUNC_READ, 8'h00, 7'd3, 10'd0);       // short: two bytes left
      send_item(FUNC_READ_OFS, 8'h00, 7'd0, OFS_W'(MAX_READ + 2));  // offset at pending
      send_item(FUNC_READ_OFS, 8'h00, 7'd2, OFS_W'(MAX_READ));
      send_item(FUNC_COMMIT, 8'h00, 7'd0, 10'd0);
      send_item(FUNC_WRITE, 8'hC3, 7'd0, 10'd0);
      wait_drained();
   endtask

   // One random item, mostly well formed against the shadow state so reads
   // succeed; the rest is any code with any fields.
   task automatic send_random_item();
      int pick;
      int unread;
      int held;
      int span;
      logic [FUNC_W-1:0] f;
      logic [DATA_W-1:0] d;
      logic [LEN_W-1:0]  len;
      logic [OFS_W-1:0]  ofs;
      unread = int'(ptr_dist(mirror_rd, mirror_wr));
      held   = int'(ptr_dist(mirror_mark, mirror_wr));
      d      = DATA_W'($urandom);
      len    = LEN_W'($urandom);
      ofs    = OFS_W'($urandom);
      pick   = $urandom_range(99);
      if (pick < 38) begin
         f = FUNC_WRITE;
      end else if (pick < 56) begin
         f = FUNC_READ;
         span = ($urandom_range(9) == 0) ? MAX_READ : 12;
         len = LEN_W'($urandom_range((unread > span) ? span : unread));
      end else if (pick < 66) begin
         f = FUNC_READ_OFS;
         ofs = OFS_W'($urandom_range(held));
         span = held - int'(ofs);
         len = LEN_W'($urandom_range((span > 12) ? 12 : span));
      end else if (pick < 76) begin
         f = FUNC_COMMIT;
      end else if (pick < 83) begin
         f = FUNC_ROLLBACK;
      end else if (pick < 85) begin
         f = FUNC_CLEAR;
      end else begin
         f = FUNC_W'($urandom);
      end
      send_item(f, d, len, ofs);
   endtask

   // Random traffic under each idling pattern, with a full drain after the first batch and at the end.
   task automatic test_random_traffic();
      tx_idle_pct = 34;
      rx_idle_pct = 66;
      repeat (9) send_random_item();
      wait_drained();
      repeat (9) send_random_item();
      tx_idle_pct = 66;
      rx_idle_pct = 34;
      repeat (9) send_random_item();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (9) send_random_item();
      wait_drained();
   endtask

   // Receiver: stall at the current rate, re-rolled every cycle.
   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         n_fail++;
      end
   endtask

   // Match every accepted response against the oldest owed one.
   always @(posedge clock) begin : rsp_check
      fifo_rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (due_rsp_q.size() == 0) begin
            $error("response with none owed: status %0d rd_data %0d last %0d",
                   rsp.status, rsp.rd_data, rsp.last);
            n_fail++;
         end else begin
            want = due_rsp_q.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp.status));
            compare_field("rd_data", 32'(want.rd_data), 32'(rsp.rd_data));
            compare_field("last", 32'(want.last), 32'(rsp.last));
            compare_field("pending", 32'(want.pending), 32'(rsp.pending));
            compare_field("is_full", 32'(want.is_full), 32'(rsp.is_full));
            compare_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
         end
      end
   end

   // Watchdog: end the run when neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req.valid     = 1'b0;
      req.func      = FUNC_STATUS;
      req.wr_data   = '0;
      req.rd_length = '0;
      req.rd_offset = '0;
      rsp.ready     = 1'b0;
      mirror_wr     = '0;
      mirror_rd     = '0;
      mirror_mark   = '0;
      n_fail        = 0;
      quiet_cycles  = 0;
      tx_idle_pct   = 0;
      rx_idle_pct   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_burst();
      test_random_traffic();

      // Let the pipeline settle, then flag anything still owed or stray.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (due_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", due_rsp_q.size());
         n_fail++;
      end
      if (n_fail == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
